### rtl/core/aarh_pkg.sv
// Package with the request and response types and the register indices of the rectangle hit core.
`timescale 1ns / 1ps

package aarh_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int UV_BITS           = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_AXIS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_LOW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_LOW   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_HIGH  = 3'd5;

   localparam logic [1:0] AXIS_XY = 2'd0;
   localparam logic [1:0] AXIS_XZ = 2'd1;
   localparam logic [1:0] AXIS_YZ = 2'd2;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] dist_min;
      logic signed [31:0] dist_max;
   } req_type;

   typedef struct packed {
      logic               is_hit;
      logic signed [31:0] hit_dist;
      logic        [16:0] surf_u;
      logic        [16:0] surf_v;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               front_face;
   } rsp_type;

endpackage

### rtl/core/axis_aligned_rect_ray_hit_core.sv
// Top level of the ray versus axis-aligned rectangle hit core.
// A request runs through the distance divider and then the u and v dividers to the response.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the bit-per-stage distance divider (33 stages) and the
// bit-per-stage u and v dividers (17 stages). Synchronous reset clears the
// valid bits and loads the default rectangle, a unit square in the XY plane.
`timescale 1ns / 1ps

module axis_aligned_rect_ray_hit_core #(
   parameter int FRAC_BITS = aarh_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  aarh_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output aarh_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [aarh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aarh_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import aarh_pkg::*;

   localparam int NW        = 33 + FRAC_BITS;
   localparam int RW        = (NW > 64) ? NW : 64;
   localparam int DIV_STEPS = 33;
   localparam int PW        = ((64 - FRAC_BITS > 32) ? (64 - FRAC_BITS) : 32) + 1;
   localparam int UW        = 33 + UV_BITS;
   localparam int UV_STEPS  = UV_BITS + 1;
   localparam int LATENCY   = DIV_STEPS + UV_STEPS + 6;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] oz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [31:0] smin;
      logic signed [31:0] smax;
      logic        [1:0]  axis;
      logic               front;
   } ray_type;

   typedef struct packed {
      ray_type          ray;
      logic [RW-1:0]    rem;
      logic [31:0]      dmag;
      logic [31:0]      quo;
      logic             neg;
      logic             miss;
   } div_type;

   typedef struct packed {
      ray_type            ray;
      logic signed [31:0] s;
      logic               miss;
   } dist_type;

   typedef struct packed {
      ray_type            ray;
      logic signed [31:0] s;
      logic               miss;
      logic signed [63:0] prod_x;
      logic signed [63:0] prod_y;
      logic signed [63:0] prod_z;
   } mul_type;

   typedef struct packed {
      logic        [1:0]    axis;
      logic                 front;
      logic signed [31:0]   s;
      logic                 miss;
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] py;
      logic signed [PW-1:0] pz;
   } pt_type;

   typedef struct packed {
      logic                 hit;
      logic signed [31:0]   s;
      logic signed [31:0]   px;
      logic signed [31:0]   py;
      logic signed [31:0]   pz;
      logic                 front;
      logic [UW-1:0]        u_rem;
      logic [32:0]          u_span;
      logic [UV_BITS:0]     u_quo;
      logic                 u_zero;
      logic [UW-1:0]        v_rem;
      logic [32:0]          v_span;
      logic [UV_BITS:0]     v_quo;
      logic                 v_zero;
   } uv_type;

   logic        [1:0]  cfg_axis_ff;
   logic signed [31:0] cfg_k_ff;
   logic signed [31:0] cfg_flo_ff;
   logic signed [31:0] cfg_fhi_ff;
   logic signed [31:0] cfg_slo_ff;
   logic signed [31:0] cfg_shi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_axis_ff <= AXIS_XY;
         cfg_k_ff    <= 32'sd0;
         cfg_flo_ff  <= 32'sd0;
         cfg_fhi_ff  <= 32'sd65536;
         cfg_slo_ff  <= 32'sd0;
         cfg_shi_ff  <= 32'sd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLANE_AXIS:   cfg_axis_ff <= csr_wdata[1:0];
            CSR_PLANE_OFFSET: cfg_k_ff    <= csr_wdata;
            CSR_FIRST_LOW:    cfg_flo_ff  <= csr_wdata;
            CSR_FIRST_HIGH:   cfg_fhi_ff  <= csr_wdata;
            CSR_SECOND_LOW:   cfg_slo_ff  <= csr_wdata;
            CSR_SECOND_HIGH:  cfg_shi_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Entry stage: pick the normal axis and form the divider operands.
   div_type            entry_in;
   logic signed [31:0] on;
   logic signed [31:0] dn;
   logic signed [32:0] num;
   logic        [32:0] nmag;
   logic               bad_axis;

   always_comb begin
      bad_axis = 1'b0;
      case (cfg_axis_ff)
         AXIS_XY: begin
            on = req_data.origin_z;
            dn = req_data.dir_z;
         end
         AXIS_XZ: begin
            on = req_data.origin_y;
            dn = req_data.dir_y;
         end
         AXIS_YZ: begin
            on = req_data.origin_x;
            dn = req_data.dir_x;
         end
         default: begin
            on = req_data.origin_z;
            dn = req_data.dir_z;
            bad_axis = 1'b1;
         end
      endcase
      num  = {cfg_k_ff[31], cfg_k_ff} - {on[31], on};
      nmag = num[32] ? 33'(-num) : 33'(num);
      entry_in.ray.ox   = req_data.origin_x;
      entry_in.ray.oy   = req_data.origin_y;
      entry_in.ray.oz   = req_data.origin_z;
      entry_in.ray.dx   = req_data.dir_x;
      entry_in.ray.dy   = req_data.dir_y;
      entry_in.ray.dz   = req_data.dir_z;
      entry_in.ray.smin = req_data.dist_min;
      entry_in.ray.smax = req_data.dist_max;
      entry_in.ray.axis = cfg_axis_ff;
      entry_in.ray.front = dn[31];
      entry_in.rem  = RW'({nmag, {FRAC_BITS{1'b0}}});
      entry_in.dmag = dn[31] ? 32'(-dn) : 32'(dn);
      entry_in.quo  = 32'd0;
      entry_in.neg  = num[32] ^ dn[31];
      entry_in.miss = bad_axis || (dn == 32'sd0);
   end

   div_type dv_ff  [0:DIV_STEPS];
   logic    dv_vld_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= start;
      end
      dv_ff[0] <= entry_in;
   end

   // Restoring divider, one quotient bit per stage; the first stage flags
   // quotients of 2^32 and above.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      div_type       step_in;
      logic [RW-1:0] shd;

      if (k == 0) begin : g_range
         always_comb begin
            step_in = dv_ff[k];
            shd = RW'(dv_ff[k].dmag) << 32;
            if (dv_ff[k].rem >= shd) begin
               step_in.miss = 1'b1;
            end
         end
      end else begin : g_step
         always_comb begin
            step_in = dv_ff[k];
            shd = RW'(dv_ff[k].dmag) << (DIV_STEPS - 1 - k);
            if (dv_ff[k].rem >= shd) begin
               step_in.rem = dv_ff[k].rem - shd;
               step_in.quo[DIV_STEPS-1-k] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
         dv_ff[k+1] <= step_in;
      end
   end

   // Signed distance, range and window check.
   dist_type dist_in;
   dist_type dist_ff;
   logic     dist_vld_ff;
   logic     dist_ovf;

   always_comb begin
      dist_in.ray = dv_ff[DIV_STEPS].ray;
      if (dv_ff[DIV_STEPS].neg) begin
         dist_ovf  = dv_ff[DIV_STEPS].quo > 32'h8000_0000;
         dist_in.s = 32'(-dv_ff[DIV_STEPS].quo);
      end else begin
         dist_ovf  = dv_ff[DIV_STEPS].quo[31];
         dist_in.s = dv_ff[DIV_STEPS].quo;
      end
      dist_in.miss = dv_ff[DIV_STEPS].miss || dist_ovf ||
                     (dist_in.s < dist_in.ray.smin) || (dist_in.s > dist_in.ray.smax);
   end

   // Products of the distance with each direction component.
   mul_type mul_in;
   mul_type mul_ff;
   logic    mul_vld_ff;

   always_comb begin
      mul_in.ray    = dist_ff.ray;
      mul_in.s      = dist_ff.s;
      mul_in.miss   = dist_ff.miss;
      mul_in.prod_x = 64'(dist_ff.s) * 64'(dist_ff.ray.dx);
      mul_in.prod_y = 64'(dist_ff.s) * 64'(dist_ff.ray.dy);
      mul_in.prod_z = 64'(dist_ff.s) * 64'(dist_ff.ray.dz);
   end

   // Hit point, exact width.
   pt_type             pt_in;
   pt_type             pt_ff;
   logic               pt_vld_ff;
   logic signed [63:0] shx;
   logic signed [63:0] shy;
   logic signed [63:0] shz;

   always_comb begin
      shx = mul_ff.prod_x >>> FRAC_BITS;
      shy = mul_ff.prod_y >>> FRAC_BITS;
      shz = mul_ff.prod_z >>> FRAC_BITS;
      pt_in.axis  = mul_ff.ray.axis;
      pt_in.front = mul_ff.ray.front;
      pt_in.s     = mul_ff.s;
      pt_in.miss  = mul_ff.miss;
      pt_in.px    = PW'(mul_ff.ray.ox) + $signed(shx[PW-1:0]);
      pt_in.py    = PW'(mul_ff.ray.oy) + $signed(shy[PW-1:0]);
      pt_in.pz    = PW'(mul_ff.ray.oz) + $signed(shz[PW-1:0]);
   end

   function automatic logic signed [31:0] sat_point(input logic signed [PW-1:0] p);
      logic fits;
      fits = (&p[PW-1:31]) || !(|p[PW-1:31]);
      if (fits) begin
         sat_point = p[31:0];
      end else begin
         sat_point = p[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   endfunction

   // Bounds test and u, v divider operands.
   uv_type               bnd_in;
   logic signed [PW-1:0] pa;
   logic signed [PW-1:0] pb;
   logic signed [PW-1:0] da;
   logic signed [PW-1:0] db;
   logic signed [PW-1:0] flo_x;
   logic signed [PW-1:0] fhi_x;
   logic signed [PW-1:0] slo_x;
   logic signed [PW-1:0] shi_x;

   always_comb begin
      case (pt_ff.axis)
         AXIS_XY: begin
            pa = pt_ff.px;
            pb = pt_ff.py;
         end
         AXIS_XZ: begin
            pa = pt_ff.px;
            pb = pt_ff.pz;
         end
         default: begin
            pa = pt_ff.py;
            pb = pt_ff.pz;
         end
      endcase
      flo_x = PW'(cfg_flo_ff);
      fhi_x = PW'(cfg_fhi_ff);
      slo_x = PW'(cfg_slo_ff);
      shi_x = PW'(cfg_shi_ff);
      da    = pa - flo_x;
      db    = pb - slo_x;
      bnd_in.hit    = !pt_ff.miss && (pa >= flo_x) && (pa <= fhi_x) &&
                      (pb >= slo_x) && (pb <= shi_x);
      bnd_in.s      = pt_ff.s;
      bnd_in.px     = sat_point(pt_ff.px);
      bnd_in.py     = sat_point(pt_ff.py);
      bnd_in.pz     = sat_point(pt_ff.pz);
      bnd_in.front  = pt_ff.front;
      bnd_in.u_rem  = {da[32:0], {UV_BITS{1'b0}}};
      bnd_in.u_span = 33'({cfg_fhi_ff[31], cfg_fhi_ff} - {cfg_flo_ff[31], cfg_flo_ff});
      bnd_in.u_quo  = '0;
      bnd_in.u_zero = (cfg_fhi_ff == cfg_flo_ff);
      bnd_in.v_rem  = {db[32:0], {UV_BITS{1'b0}}};
      bnd_in.v_span = 33'({cfg_shi_ff[31], cfg_shi_ff} - {cfg_slo_ff[31], cfg_slo_ff});
      bnd_in.v_quo  = '0;
      bnd_in.v_zero = (cfg_shi_ff == cfg_slo_ff);
   end

   uv_type uv_ff     [0:UV_STEPS];
   logic   uv_vld_ff [0:UV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff  <= 1'b0;
         mul_vld_ff   <= 1'b0;
         pt_vld_ff    <= 1'b0;
         uv_vld_ff[0] <= 1'b0;
      end else begin
         dist_vld_ff  <= dv_vld_ff[DIV_STEPS];
         mul_vld_ff   <= dist_vld_ff;
         pt_vld_ff    <= mul_vld_ff;
         uv_vld_ff[0] <= pt_vld_ff;
      end
      dist_ff   <= dist_in;
      mul_ff    <= mul_in;
      pt_ff     <= pt_in;
      uv_ff[0]  <= bnd_in;
   end

   // Two restoring dividers side by side for u and v, one bit per stage.
   for (genvar k = 0; k < UV_STEPS; k++) begin : g_uv
      uv_type        step_in;
      logic [UW-1:0] shu;
      logic [UW-1:0] shv;

      always_comb begin
         step_in = uv_ff[k];
         shu = UW'(uv_ff[k].u_span) << (UV_STEPS - 1 - k);
         shv = UW'(uv_ff[k].v_span) << (UV_STEPS - 1 - k);
         if (uv_ff[k].u_rem >= shu) begin
            step_in.u_rem = uv_ff[k].u_rem - shu;
            step_in.u_quo[UV_STEPS-1-k] = 1'b1;
         end
         if (uv_ff[k].v_rem >= shv) begin
            step_in.v_rem = uv_ff[k].v_rem - shv;
            step_in.v_quo[UV_STEPS-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            uv_vld_ff[k+1] <= 1'b0;
         end else begin
            uv_vld_ff[k+1] <= uv_vld_ff[k];
         end
         uv_ff[k+1] <= step_in;
      end
   end

   rsp_type rsp_in;
   rsp_type rsp_data_ff;
   logic    rsp_strobe_ff;

   always_comb begin
      rsp_in = '0;
      if (uv_ff[UV_STEPS].hit) begin
         rsp_in.is_hit     = 1'b1;
         rsp_in.hit_dist   = uv_ff[UV_STEPS].s;
         rsp_in.surf_u     = uv_ff[UV_STEPS].u_zero ? 17'd0 : uv_ff[UV_STEPS].u_quo;
         rsp_in.surf_v     = uv_ff[UV_STEPS].v_zero ? 17'd0 : uv_ff[UV_STEPS].v_quo;
         rsp_in.point_x    = uv_ff[UV_STEPS].px;
         rsp_in.point_y    = uv_ff[UV_STEPS].py;
         rsp_in.point_z    = uv_ff[UV_STEPS].pz;
         rsp_in.front_face = uv_ff[UV_STEPS].front;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= uv_vld_ff[UV_STEPS];
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // A request taken now is answered later by a response strobe.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("response strobe missing after request");

   // A miss carries all-zero fields.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.is_hit) |-> (rsp_data == '0))
      else $error("miss response with nonzero fields");

   // Surface coordinates never exceed one.
   a_uv_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_hit) |->
      ((rsp_data.surf_u <= 17'd65536) && (rsp_data.surf_v <= 17'd65536)))
      else $error("surface coordinate above one");

endmodule
